/* design/hsv2rgb_pkg.sv */
// Shared types and constants for the HSV to RGB pixel converter.
package hsv2rgb_pkg;

    localparam int HUE_W  = 16;
    localparam int REG_W  = 13;
    localparam int CH_W   = 8;
    localparam int REM_W  = 13;
    localparam int K_W    = 25;
    localparam int W_W    = 20;
    localparam int PROD_W = 45;
    localparam int ADDR_W = 2;

    localparam logic [REG_W-1:0]  Q_ONE      = 13'd4096;
    localparam logic [REG_W-1:0]  SAT_RESET  = 13'd3277;
    localparam logic [REG_W-1:0]  VAL_RESET  = 13'd3277;
    localparam logic [HUE_W-1:0]  HUE_FULL   = 16'd46080;
    localparam logic [HUE_W-1:0]  HUE_SECTOR = 16'd7680;
    localparam logic [REM_W-1:0]  SECTOR_W   = 13'd7680;
    localparam logic [K_W-1:0]    K_FULL     = 25'd31457280;
    // floor(y / 15) = (y * 4370) >> 16 for y < 4096
    localparam logic [12:0]       RECIP15    = 13'd4370;

    localparam logic [ADDR_W-1:0] REG_SATURATION = 2'd0;
    localparam logic [ADDR_W-1:0] REG_BRIGHTNESS = 2'd1;

    typedef enum logic [2:0] {
        SEC_0 = 3'd0,
        SEC_1 = 3'd1,
        SEC_2 = 3'd2,
        SEC_3 = 3'd3,
        SEC_4 = 3'd4,
        SEC_5 = 3'd5
    } t_sector;

    typedef struct packed {
        logic [K_W-1:0] k_r;
        logic [K_W-1:0] k_g;
        logic [K_W-1:0] k_b;
    } t_kset;

    typedef struct packed {
        logic [CH_W-1:0] red;
        logic [CH_W-1:0] green;
        logic [CH_W-1:0] blue;
    } t_rgb;

    function automatic logic [HUE_W-1:0] sector_base(input t_sector sec);
        logic [HUE_W-1:0] base;
        case (sec)
            SEC_0:   base = 16'd0;
            SEC_1:   base = 16'd7680;
            SEC_2:   base = 16'd15360;
            SEC_3:   base = 16'd23040;
            SEC_4:   base = 16'd30720;
            SEC_5:   base = 16'd38400;
            default: base = 16'd0;
        endcase
        return base;
    endfunction

endpackage

/* design/hsv2rgb_fifo.sv */
// Small register queue with item count.
module hsv2rgb_fifo #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  logic                       i_push,
    input  logic [WIDTH-1:0]           i_data,
    input  logic                       i_pop,
    output logic [WIDTH-1:0]           o_data,
    output logic [$clog2(DEPTH+1)-1:0] o_count
);
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [AW-1:0]    r_wr;
    logic [AW-1:0]    r_rd;
    logic [CW-1:0]    r_count;

    always_ff @(posedge i_clk) begin
        if (i_push) begin
            r_mem[r_wr] <= i_data;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr    <= '0;
            r_rd    <= '0;
            r_count <= '0;
        end else begin
            if (i_push) begin
                r_wr <= (r_wr == AW'(DEPTH - 1)) ? '0 : r_wr + 1'b1;
            end
            if (i_pop) begin
                r_rd <= (r_rd == AW'(DEPTH - 1)) ? '0 : r_rd + 1'b1;
            end
            case ({i_push, i_pop})
                2'b10:   r_count <= r_count + 1'b1;
                2'b01:   r_count <= r_count - 1'b1;
                default: r_count <= r_count;
            endcase
        end
    end

    assign o_data  = r_mem[r_rd];
    assign o_count = r_count;
endmodule

/* design/hsv2rgb_front.sv */
// Front end: hue wrap, sector split and per-channel K terms.
module hsv2rgb_front (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic                           i_valid,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]  i_hue,
    input  logic [hsv2rgb_pkg::REG_W-1:0]  i_sat,
    output logic                           o_valid,
    output hsv2rgb_pkg::t_kset             o_kset,
    output logic [1:0]                     o_inflight
);
    logic [hsv2rgb_pkg::HUE_W-1:0] hh;
    logic [hsv2rgb_pkg::HUE_W-1:0] rem_full;
    hsv2rgb_pkg::t_sector          sec;

    logic                          r_a_valid;
    hsv2rgb_pkg::t_sector          r_a_sec;
    logic [hsv2rgb_pkg::REM_W-1:0] r_a_rem;

    logic [2*hsv2rgb_pkg::REM_W-1:0] p_q;
    logic [2*hsv2rgb_pkg::REM_W-1:0] p_t;
    logic [2*hsv2rgb_pkg::REM_W-1:0] p_p;
    logic [hsv2rgb_pkg::K_W-1:0]     kv;
    logic [hsv2rgb_pkg::K_W-1:0]     kp;
    logic [hsv2rgb_pkg::K_W-1:0]     kq;
    logic [hsv2rgb_pkg::K_W-1:0]     kt;
    hsv2rgb_pkg::t_kset              kset;

    logic                r_b_valid;
    hsv2rgb_pkg::t_kset  r_b_kset;

    always_comb begin
        hh = (i_hue >= hsv2rgb_pkg::HUE_FULL) ? i_hue - hsv2rgb_pkg::HUE_FULL : i_hue;
        if (hh < hsv2rgb_pkg::HUE_SECTOR) begin
            sec = hsv2rgb_pkg::SEC_0;
        end else if (hh < 16'd15360) begin
            sec = hsv2rgb_pkg::SEC_1;
        end else if (hh < 16'd23040) begin
            sec = hsv2rgb_pkg::SEC_2;
        end else if (hh < 16'd30720) begin
            sec = hsv2rgb_pkg::SEC_3;
        end else if (hh < 16'd38400) begin
            sec = hsv2rgb_pkg::SEC_4;
        end else begin
            sec = hsv2rgb_pkg::SEC_5;
        end
        rem_full = hh - hsv2rgb_pkg::sector_base(sec);
    end

    always_ff @(posedge i_clk) begin
        r_a_sec <= sec;
        r_a_rem <= rem_full[hsv2rgb_pkg::REM_W-1:0];
    end

    // K = 4096*7680 - s*x for x in {0, 7680, rem, 7680-rem}
    always_comb begin
        p_q = i_sat * r_a_rem;
        p_t = i_sat * (hsv2rgb_pkg::SECTOR_W - r_a_rem);
        p_p = i_sat * hsv2rgb_pkg::SECTOR_W;
        kv  = hsv2rgb_pkg::K_FULL;
        kp  = hsv2rgb_pkg::K_FULL - p_p[hsv2rgb_pkg::K_W-1:0];
        kq  = hsv2rgb_pkg::K_FULL - p_q[hsv2rgb_pkg::K_W-1:0];
        kt  = hsv2rgb_pkg::K_FULL - p_t[hsv2rgb_pkg::K_W-1:0];
        case (r_a_sec)
            hsv2rgb_pkg::SEC_0: kset = '{k_r: kv, k_g: kt, k_b: kp};
            hsv2rgb_pkg::SEC_1: kset = '{k_r: kq, k_g: kv, k_b: kp};
            hsv2rgb_pkg::SEC_2: kset = '{k_r: kp, k_g: kv, k_b: kt};
            hsv2rgb_pkg::SEC_3: kset = '{k_r: kp, k_g: kq, k_b: kv};
            hsv2rgb_pkg::SEC_4: kset = '{k_r: kt, k_g: kp, k_b: kv};
            default:            kset = '{k_r: kv, k_g: kp, k_b: kq};
        endcase
    end

    always_ff @(posedge i_clk) begin
        r_b_kset <= kset;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_a_valid <= 1'b0;
            r_b_valid <= 1'b0;
        end else begin
            r_a_valid <= i_valid;
            r_b_valid <= r_a_valid;
        end
    end

    assign o_valid    = r_b_valid;
    assign o_kset     = r_b_kset;
    assign o_inflight = {1'b0, r_a_valid} + {1'b0, r_b_valid};
endmodule

/* design/hsv2rgb_back.sv */
// Back end: channel = floor(255*v*K / (4096*4096*7680)) per lane.
module hsv2rgb_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_valid,
    input  hsv2rgb_pkg::t_kset            i_kset,
    input  logic [hsv2rgb_pkg::W_W-1:0]   i_w,
    output logic                          o_valid,
    output hsv2rgb_pkg::t_rgb             o_rgb,
    output logic                          o_inflight
);
    logic                             r_valid;
    logic [hsv2rgb_pkg::PROD_W-1:0]   r_m_r;
    logic [hsv2rgb_pkg::PROD_W-1:0]   r_m_g;
    logic [hsv2rgb_pkg::PROD_W-1:0]   r_m_b;
    logic [24:0]                      d_r;
    logic [24:0]                      d_g;
    logic [24:0]                      d_b;

    always_ff @(posedge i_clk) begin
        r_m_r <= i_w * i_kset.k_r;
        r_m_g <= i_w * i_kset.k_g;
        r_m_b <= i_w * i_kset.k_b;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else begin
            r_valid <= i_valid;
        end
    end

    // divide by 2^33, then by 15 through the reciprocal
    always_comb begin
        d_r = r_m_r[44:33] * hsv2rgb_pkg::RECIP15;
        d_g = r_m_g[44:33] * hsv2rgb_pkg::RECIP15;
        d_b = r_m_b[44:33] * hsv2rgb_pkg::RECIP15;
        o_rgb.red   = d_r[23:16];
        o_rgb.green = d_g[23:16];
        o_rgb.blue  = d_b[23:16];
    end

    assign o_valid    = r_valid;
    assign o_inflight = r_valid;
endmodule

/* design/hsv_to_rgb_pixel_converter.sv */
// Top level of the HSV to RGB pixel converter.
// An accepted item passes the front stages, middle queue, back stage and output queue.
// Throughput: one item per cycle while full is low; the back stage waits for queue room.
// full rises when the middle queue plus front items in flight reach MID_DEPTH.
// Reset (synchronous, active low) empties both queues and the pipelines and
// sets saturation and brightness to 3277.
module hsv_to_rgb_pixel_converter #(
    parameter int MID_DEPTH = 4,
    parameter int OUT_DEPTH = 4
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            push,
    output logic                            full,
    input  logic [hsv2rgb_pkg::HUE_W-1:0]   i_hue,
    output logic                            empty,
    input  logic                            pop,
    output logic [hsv2rgb_pkg::CH_W-1:0]    o_red,
    output logic [hsv2rgb_pkg::CH_W-1:0]    o_green,
    output logic [hsv2rgb_pkg::CH_W-1:0]    o_blue,
    input  logic                            i_cfg_we,
    input  logic [hsv2rgb_pkg::ADDR_W-1:0]  i_cfg_addr,
    input  logic [hsv2rgb_pkg::REG_W-1:0]   i_cfg_wdata
);
    localparam int MCW = $clog2(MID_DEPTH + 1);
    localparam int MSW = $clog2(MID_DEPTH + 3);
    localparam int OCW = $clog2(OUT_DEPTH + 1);
    localparam int OSW = $clog2(OUT_DEPTH + 2);
    localparam int KSW = $bits(hsv2rgb_pkg::t_kset);
    localparam int RGW = $bits(hsv2rgb_pkg::t_rgb);

    logic [hsv2rgb_pkg::REG_W-1:0] r_sat;
    logic [hsv2rgb_pkg::REG_W-1:0] r_bright;
    logic [hsv2rgb_pkg::REG_W-1:0] sat_cl;
    logic [hsv2rgb_pkg::REG_W-1:0] bright_cl;
    logic [hsv2rgb_pkg::W_W:0]     w_wide;
    logic [hsv2rgb_pkg::W_W-1:0]   w;

    logic                  in_acc;
    logic                  f_valid;
    hsv2rgb_pkg::t_kset    f_kset;
    logic [1:0]            f_inflight;
    logic [KSW-1:0]        mid_data;
    logic [MCW-1:0]        mid_count;
    logic                  mid_pop;
    hsv2rgb_pkg::t_kset    mid_kset;
    logic                  b_valid;
    hsv2rgb_pkg::t_rgb     b_rgb;
    logic                  b_inflight;
    logic [RGW-1:0]        out_data;
    logic [OCW-1:0]        out_count;
    logic                  out_pop;
    hsv2rgb_pkg::t_rgb     out_rgb;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_sat    <= hsv2rgb_pkg::SAT_RESET;
            r_bright <= hsv2rgb_pkg::VAL_RESET;
        end else if (i_cfg_we) begin
            case (i_cfg_addr)
                hsv2rgb_pkg::REG_SATURATION: r_sat    <= i_cfg_wdata;
                hsv2rgb_pkg::REG_BRIGHTNESS: r_bright <= i_cfg_wdata;
                default: ;
            endcase
        end
    end

    always_comb begin
        sat_cl    = (r_sat > hsv2rgb_pkg::Q_ONE) ? hsv2rgb_pkg::Q_ONE : r_sat;
        bright_cl = (r_bright > hsv2rgb_pkg::Q_ONE) ? hsv2rgb_pkg::Q_ONE : r_bright;
        w_wide    = {bright_cl, 8'd0} - {8'd0, bright_cl};
        w         = w_wide[hsv2rgb_pkg::W_W-1:0];
    end

    assign full   = (MSW'(mid_count) + MSW'(f_inflight)) >= MSW'(MID_DEPTH);
    assign in_acc = push && !full;

    hsv2rgb_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (in_acc),
        .i_hue      (i_hue),
        .i_sat      (sat_cl),
        .o_valid    (f_valid),
        .o_kset     (f_kset),
        .o_inflight (f_inflight)
    );

    hsv2rgb_fifo #(
        .WIDTH (KSW),
        .DEPTH (MID_DEPTH)
    ) u_mid_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (f_valid),
        .i_data  (f_kset),
        .i_pop   (mid_pop),
        .o_data  (mid_data),
        .o_count (mid_count)
    );

    assign mid_kset = mid_data;
    assign mid_pop  = (mid_count != '0)
                   && ((OSW'(out_count) + OSW'(b_inflight)) < OSW'(OUT_DEPTH));

    hsv2rgb_back u_back (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_valid    (mid_pop),
        .i_kset     (mid_kset),
        .i_w        (w),
        .o_valid    (b_valid),
        .o_rgb      (b_rgb),
        .o_inflight (b_inflight)
    );

    hsv2rgb_fifo #(
        .WIDTH (RGW),
        .DEPTH (OUT_DEPTH)
    ) u_out_q (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (b_valid),
        .i_data  (b_rgb),
        .i_pop   (out_pop),
        .o_data  (out_data),
        .o_count (out_count)
    );

    assign empty   = (out_count == '0);
    assign out_pop = pop && !empty;
    assign out_rgb = out_data;
    assign o_red   = out_rgb.red;
    assign o_green = out_rgb.green;
    assign o_blue  = out_rgb.blue;
endmodule

/* design/hsv2rgb_checker.sv */
// Port-level checker for the HSV to RGB pixel converter, with its bind.
module hsv2rgb_checker (
    input logic                           i_clk,
    input logic                           i_rst_n,
    input logic                           push,
    input logic                           full,
    input logic                           empty,
    input logic                           pop,
    input logic [hsv2rgb_pkg::CH_W-1:0]   o_red,
    input logic [hsv2rgb_pkg::CH_W-1:0]   o_green,
    input logic [hsv2rgb_pkg::CH_W-1:0]   o_blue
);
    a_reset_empty: assert property (@(posedge i_clk) !i_rst_n |=> empty)
        else $error("queue not empty after reset");

    a_reset_not_full: assert property (@(posedge i_clk) !i_rst_n |=> !full)
        else $error("full after reset");

    a_result_held: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !empty && !pop |=> !empty && $stable(o_red) && $stable(o_green)
                           && $stable(o_blue))
        else $error("waiting result changed");

    a_full_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(full) |-> $past(push && !full))
        else $error("full rose without an accepted item");
endmodule

bind hsv_to_rgb_pixel_converter hsv2rgb_checker u_chk (
    .i_clk   (i_clk),
    .i_rst_n (i_rst_n),
    .push    (push),
    .full    (full),
    .empty   (empty),
    .pop     (pop),
    .o_red   (o_red),
    .o_green (o_green),
    .o_blue  (o_blue)
);
